// ===== design/top_p_token_sampler_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the nucleus token sampler
// Concurrent checks that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TOP_P_TOKEN_SAMPLER_DEFINES_SVH
`define TOP_P_TOKEN_SAMPLER_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define TPS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tps assertion failed");
// Check that a condition never holds.
`define TPS_NEVER(lbl, cond) `TPS_ASSERT(lbl, !(cond))
`else
`define TPS_ASSERT(lbl, prop)
`define TPS_NEVER(lbl, cond)
`endif

`endif

// ===== design/tps_pkg.sv =====
// ----------------------------------------------------------------------------
// Nucleus token sampler package
// Widths, constants, shared types and helper functions.
// ----------------------------------------------------------------------------
package tps_pkg;

    localparam int VOCAB_SIZE = 65536;
    localparam int IW         = $clog2(VOCAB_SIZE);
    localparam int CW         = $clog2(VOCAB_SIZE + 1);
    localparam int TOKEN_W    = 16;
    localparam int LOGIT_W    = 32;
    localparam int TEMP_W     = 16;
    localparam int TOPP_W     = 17;
    localparam int SEED_W     = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int W_W        = 33;
    localparam int P_W        = 25;
    localparam int SUM_W      = 32 + CW;
    localparam int CUM_W      = 26;
    localparam int TGT_W      = 24 + CUM_W;
    localparam int Y_W        = 23;
    localparam int WARM_W     = 4;
    localparam int QDEPTH     = 2;
    localparam int DIV_W      = 64;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

    localparam logic [16:0]         LOG2E_Q16  = 17'd94548;
    localparam logic [63:0]         POW2_STEP  = 64'd4283353946;
    localparam logic [63:0]         SEED_MASK  = 64'hdeadbeefcafe1234;
    localparam logic [63:0]         RNG_RESET  = 64'h853c49e6748fea9b;
    localparam logic [TEMP_W-1:0]   TEMP_RESET = 16'd256;
    localparam logic [TOPP_W-1:0]   TOPP_ONE   = 17'd65536;
    localparam logic [WARM_W-1:0]   WARM_ROUNDS = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMPERATURE = 2'd0,
        CFG_TOP_P       = 2'd1,
        CFG_RNG_SEED    = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_EXP_RD,
        ST_EXP_DIV,
        ST_EXP_WAIT,
        ST_EXP_W,
        ST_NORM_RD,
        ST_NORM_DIV,
        ST_NORM_WAIT,
        ST_SEL_SCAN,
        ST_SEL_COMMIT,
        ST_SAMP_RNG,
        ST_SAMP_MUL,
        ST_SAMP_RD,
        ST_SAMP_CHK,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic signed [LOGIT_W-1:0] logit;
        logic [IW-1:0]             idx;
        logic                      store;
        logic                      last;
        logic [CW-1:0]             n;
        logic signed [LOGIT_W-1:0] mx;
        logic [IW-1:0]             amax;
    } q_entry_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIV_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quotient;
    } div_rsp_t;

    typedef struct packed {
        logic [IW-1:0]  idx;
        logic [P_W-1:0] p;
    } order_ent_t;

    typedef logic [255:0][W_W-1:0] pow2_tab_t;

    function automatic logic [63:0] xs_round(input logic [63:0] s);
        logic [63:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 7);
        t = t ^ (t << 17);
        return t;
    endfunction

    // 2^(-j/256) in Q1.32, built at elaboration
    function automatic pow2_tab_t build_pow2();
        pow2_tab_t   t;
        logic [63:0] v;
        v    = 64'h1_0000_0000;
        t[0] = v[W_W-1:0];
        for (int j = 0; j < 255; j++)
        begin
            v        = (v * POW2_STEP + 64'h8000_0000) >> 32;
            t[j + 1] = v[W_W-1:0];
        end
        return t;
    endfunction

    localparam pow2_tab_t POW2_TAB = build_pow2();

endpackage

// ===== design/tps_logit_if.sv =====
// ----------------------------------------------------------------------------
// Logit stream interface
// One logit per transaction, with a flag on the final one.
// ----------------------------------------------------------------------------
interface tps_logit_if;
    logic                               valid;
    logic                               ready;
    logic signed [tps_pkg::LOGIT_W-1:0] logit;
    logic                               last_logit;

    modport source (output valid, output logit, output last_logit, input ready);
    modport sink   (input valid, input logit, input last_logit, output ready);
endinterface

// ===== design/tps_token_if.sv =====
// ----------------------------------------------------------------------------
// Token result interface
// One selected token index per transaction.
// ----------------------------------------------------------------------------
interface tps_token_if;
    logic                        valid;
    logic                        ready;
    logic [tps_pkg::TOKEN_W-1:0] token_index;

    modport source (output valid, output token_index, input ready);
    modport sink   (input valid, input token_index, output ready);
endinterface

// ===== design/tps_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration write interface
// Register index and write data per transaction.
// ----------------------------------------------------------------------------
interface tps_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tps_pkg::CFG_IDX_W-1:0] index;
    logic [tps_pkg::SEED_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/tps_front.sv =====
// ----------------------------------------------------------------------------
// Sampler front end
// Accept logits, number them, track the running maximum, feed the queue.
// ----------------------------------------------------------------------------
module tps_front (
    input  logic              clk,
    input  logic              rst_n,
    tps_logit_if.sink         logits,
    output logic              push,
    output tps_pkg::q_entry_t entry,
    input  logic              full
);

    logic [tps_pkg::CW-1:0]              cnt_reg;
    logic [tps_pkg::CW-1:0]              cnt_next;
    logic signed [tps_pkg::LOGIT_W-1:0]  max_reg;
    logic signed [tps_pkg::LOGIT_W-1:0]  max_next;
    logic [tps_pkg::IW-1:0]              amax_reg;
    logic [tps_pkg::IW-1:0]              amax_next;
    logic                                store;
    logic                                new_max;
    logic [tps_pkg::CW-1:0]              n_now;

    always_comb
    begin
        logits.ready = !full;
        push         = logits.valid && !full;
        store        = cnt_reg < tps_pkg::CW'(tps_pkg::VOCAB_SIZE);
        new_max      = store && ((cnt_reg == '0) || (logits.logit > max_reg));
        max_next     = new_max ? logits.logit : max_reg;
        amax_next    = new_max ? cnt_reg[tps_pkg::IW-1:0] : amax_reg;
        n_now        = store ? cnt_reg + tps_pkg::CW'(1) : cnt_reg;
        cnt_next     = logits.last_logit ? '0 : n_now;

        entry.logit  = logits.logit;
        entry.idx    = cnt_reg[tps_pkg::IW-1:0];
        entry.store  = store;
        entry.last   = logits.last_logit;
        entry.n      = n_now;
        entry.mx     = max_next;
        entry.amax   = amax_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (push)
        begin
            cnt_reg <= cnt_next;
        end
    end

    // hold the running maximum; a zero count overrides it
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            max_reg  <= max_next;
            amax_reg <= amax_next;
        end
    end

endmodule

// ===== design/tps_fifo.sv =====
// ----------------------------------------------------------------------------
// Sampler item queue
// Short queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`include "top_p_token_sampler_defines.svh"

module tps_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tps_pkg::q_entry_t wr_data,
    output logic              full,
    input  logic              pop,
    output tps_pkg::q_entry_t rd_data,
    output logic              empty
);

    localparam int PW = $clog2(tps_pkg::QDEPTH);
    localparam int NW = $clog2(tps_pkg::QDEPTH + 1);

    tps_pkg::q_entry_t slot_reg [tps_pkg::QDEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [NW-1:0]     count_reg;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(tps_pkg::QDEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign full    = count_reg == NW'(tps_pkg::QDEPTH);
    assign empty   = count_reg == '0;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + NW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `TPS_NEVER(a_push_full, push && full)
    `TPS_NEVER(a_pop_empty, pop && empty)

endmodule

// ===== design/tps_div.sv =====
// ----------------------------------------------------------------------------
// Sampler divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tps_div (
    input  logic              clk,
    input  logic              rst_n,
    input  tps_pkg::div_req_t req,
    output tps_pkg::div_rsp_t rsp
);

    logic [tps_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          done_reg;
    logic [tps_pkg::DIV_W-1:0]     rem_reg;
    logic [tps_pkg::DIV_W-1:0]     rem_next;
    logic [tps_pkg::DIV_W-1:0]     num_reg;
    logic [tps_pkg::DIV_W-1:0]     den_reg;
    logic [tps_pkg::DIV_W:0]       trial;
    logic                          qbit;

    always_comb
    begin
        trial    = {rem_reg, num_reg[tps_pkg::DIV_W-1]};
        qbit     = trial >= {1'b0, den_reg};
        rem_next = qbit ? tps_pkg::DIV_W'(trial - {1'b0, den_reg})
                        : trial[tps_pkg::DIV_W-1:0];
        rsp.done     = done_reg;
        rsp.quotient = num_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                cnt_reg <= tps_pkg::DIV_CNT_W'(tps_pkg::DIV_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg  <= cnt_reg - tps_pkg::DIV_CNT_W'(1);
                done_reg <= cnt_reg == tps_pkg::DIV_CNT_W'(1);
            end
        end
    end

    // shift quotient bits into the dividend register as it empties
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            num_reg <= req.dividend;
            den_reg <= req.divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            num_reg <= {num_reg[tps_pkg::DIV_W-2:0], qbit};
        end
    end

endmodule

// ===== design/tps_back.sv =====
// ----------------------------------------------------------------------------
// Sampler back end
// Store logits, run softmax, ordered nucleus selection and sampling, or emit the argmax at temperature zero.
// ----------------------------------------------------------------------------
`include "top_p_token_sampler_defines.svh"

module tps_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  tps_pkg::q_entry_t q_data,
    output logic              q_pop,
    tps_token_if.source       tokens,
    tps_cfg_if.sink           cfg,
    output tps_pkg::div_req_t div_req,
    input  tps_pkg::div_rsp_t div_rsp
);

    localparam int IW = tps_pkg::IW;
    localparam int CW = tps_pkg::CW;

    logic signed [tps_pkg::LOGIT_W-1:0] logit_mem [tps_pkg::VOCAB_SIZE];
    logic [tps_pkg::W_W-1:0]            prob_mem  [tps_pkg::VOCAB_SIZE];
    tps_pkg::order_ent_t                order_mem [tps_pkg::VOCAB_SIZE];

    logic                               lmem_we;
    logic [IW-1:0]                      lmem_wa;
    logic [IW-1:0]                      lmem_ra;
    logic signed [tps_pkg::LOGIT_W-1:0] lmem_rd;
    logic                               pmem_we;
    logic [IW-1:0]                      pmem_wa;
    logic [tps_pkg::W_W-1:0]            pmem_wd;
    logic [IW-1:0]                      pmem_ra;
    logic [tps_pkg::W_W-1:0]            pmem_rd;
    logic                               omem_we;
    logic [IW-1:0]                      omem_ra;
    tps_pkg::order_ent_t                omem_wd;
    tps_pkg::order_ent_t                omem_rd;

    tps_pkg::state_t                    state_reg, state_next;
    logic [CW-1:0]                      n_reg, n_next;
    logic signed [tps_pkg::LOGIT_W-1:0] mx_reg, mx_next;
    logic [IW-1:0]                      amax_reg, amax_next;
    logic [CW-1:0]                      i_reg, i_next;
    logic [tps_pkg::SUM_W-1:0]          sum_reg, sum_next;
    logic [tps_pkg::Y_W-1:0]            y_reg, y_next;
    logic                               zw_reg, zw_next;
    logic [tps_pkg::P_W-1:0]            plast_reg, plast_next;
    logic [IW-1:0]                      ilast_reg, ilast_next;
    logic                               first_reg, first_next;
    logic [tps_pkg::P_W-1:0]            pbest_reg, pbest_next;
    logic [IW-1:0]                      ibest_reg, ibest_next;
    logic                               have_reg, have_next;
    logic                               rdv_reg, rdv_next;
    logic [IW-1:0]                      rdidx_reg, rdidx_next;
    logic [CW-1:0]                      k_reg, k_next;
    logic [tps_pkg::CUM_W-1:0]          cum_reg, cum_next;
    logic [tps_pkg::CUM_W-1:0]          ns_reg, ns_next;
    logic [CW-1:0]                      m_reg, m_next;
    logic [tps_pkg::TGT_W-1:0]          target_reg, target_next;
    logic [IW-1:0]                      res_reg, res_next;
    logic                               out_valid_reg, out_valid_next;
    logic [tps_pkg::TOKEN_W-1:0]        token_reg, token_next;
    logic [tps_pkg::TEMP_W-1:0]         temp_reg, temp_next;
    logic [tps_pkg::TOPP_W-1:0]         topp_reg, topp_next;
    logic [63:0]                        rng_reg, rng_next;
    logic [tps_pkg::WARM_W-1:0]         warm_reg, warm_next;

    logic [32:0]                        diff;
    logic [38:0]                        prod;
    logic [tps_pkg::W_W-1:0]            wval;
    logic [tps_pkg::P_W-1:0]            pcur;
    logic                               elig;
    logic [tps_pkg::CUM_W-1:0]          cum_add;
    logic [tps_pkg::TOPP_W-1:0]         topp_sat;
    logic [tps_pkg::CUM_W-1:0]          thr;
    logic [63:0]                        seed_mix;

    always_ff @(posedge clk)
    begin
        if (lmem_we)
        begin
            logit_mem[lmem_wa] <= q_data.logit;
        end
        lmem_rd <= logit_mem[lmem_ra];
    end

    always_ff @(posedge clk)
    begin
        if (pmem_we)
        begin
            prob_mem[pmem_wa] <= pmem_wd;
        end
        pmem_rd <= prob_mem[pmem_ra];
    end

    always_ff @(posedge clk)
    begin
        if (omem_we)
        begin
            order_mem[k_reg[IW-1:0]] <= omem_wd;
        end
        omem_rd <= order_mem[omem_ra];
    end

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        mx_next        = mx_reg;
        amax_next      = amax_reg;
        i_next         = i_reg;
        sum_next       = sum_reg;
        y_next         = y_reg;
        zw_next        = zw_reg;
        plast_next     = plast_reg;
        ilast_next     = ilast_reg;
        first_next     = first_reg;
        pbest_next     = pbest_reg;
        ibest_next     = ibest_reg;
        have_next      = have_reg;
        rdv_next       = 1'b0;
        rdidx_next     = rdidx_reg;
        k_next         = k_reg;
        cum_next       = cum_reg;
        ns_next        = ns_reg;
        m_next         = m_reg;
        target_next    = target_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        token_next     = token_reg;
        temp_next      = temp_reg;
        topp_next      = topp_reg;
        rng_next       = rng_reg;
        warm_next      = warm_reg;

        q_pop            = 1'b0;
        lmem_we          = 1'b0;
        lmem_wa          = q_data.idx;
        lmem_ra          = i_reg[IW-1:0];
        pmem_we          = 1'b0;
        pmem_wa          = i_reg[IW-1:0];
        pmem_wd          = '0;
        pmem_ra          = i_reg[IW-1:0];
        omem_we          = 1'b0;
        omem_ra          = i_reg[IW-1:0];
        omem_wd.idx      = ibest_reg;
        omem_wd.p        = pbest_reg;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;

        diff     = {mx_reg[tps_pkg::LOGIT_W-1], mx_reg}
                 - {lmem_rd[tps_pkg::LOGIT_W-1], lmem_rd};
        prod     = div_rsp.quotient[21:0] * tps_pkg::LOG2E_Q16;
        wval     = (zw_reg || y_reg[22]) ? '0
                 : (tps_pkg::POW2_TAB[y_reg[15:8]] >> y_reg[21:16]);
        pcur     = pmem_rd[tps_pkg::P_W-1:0];
        elig     = first_reg || (pcur < plast_reg)
                 || ((pcur == plast_reg) && (rdidx_reg > ilast_reg));
        topp_sat = (topp_reg > tps_pkg::TOPP_ONE) ? tps_pkg::TOPP_ONE : topp_reg;
        thr      = tps_pkg::CUM_W'({topp_sat, 8'b0});
        cum_add  = '0;
        seed_mix = cfg.data ^ tps_pkg::SEED_MASK;

        // result register: drop it once taken
        tokens.valid       = out_valid_reg;
        tokens.token_index = token_reg;
        if (out_valid_reg && tokens.ready)
        begin
            out_valid_next = 1'b0;
        end

        // configuration and generator warm-up
        cfg.ready = 1'b1;
        if (warm_reg != '0)
        begin
            rng_next  = tps_pkg::xs_round(rng_reg);
            warm_next = warm_reg - tps_pkg::WARM_W'(1);
        end
        if (cfg.valid)
        begin
            unique case (tps_pkg::cfg_idx_t'(cfg.index))
                tps_pkg::CFG_TEMPERATURE: temp_next = cfg.data[tps_pkg::TEMP_W-1:0];
                tps_pkg::CFG_TOP_P:       topp_next = cfg.data[tps_pkg::TOPP_W-1:0];
                tps_pkg::CFG_RNG_SEED:
                begin
                    rng_next  = (seed_mix == '0) ? 64'd1 : seed_mix;
                    warm_next = tps_pkg::WARM_ROUNDS;
                end
                default: ;
            endcase
        end

        unique case (state_reg)
            tps_pkg::ST_LOAD:
            begin
                if (q_valid)
                begin
                    q_pop   = 1'b1;
                    lmem_we = q_data.store;
                    if (q_data.last)
                    begin
                        n_next    = q_data.n;
                        mx_next   = q_data.mx;
                        amax_next = q_data.amax;
                        if (temp_reg == '0)
                        begin
                            res_next   = q_data.amax;
                            state_next = tps_pkg::ST_EMIT;
                        end
                        else
                        begin
                            i_next     = '0;
                            sum_next   = '0;
                            state_next = tps_pkg::ST_EXP_RD;
                        end
                    end
                end
            end
            tps_pkg::ST_EXP_RD:
            begin
                state_next = tps_pkg::ST_EXP_DIV;
            end
            tps_pkg::ST_EXP_DIV:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = tps_pkg::DIV_W'({diff[31:0], 8'b0});
                div_req.divisor  = tps_pkg::DIV_W'(temp_reg);
                state_next       = tps_pkg::ST_EXP_WAIT;
            end
            tps_pkg::ST_EXP_WAIT:
            begin
                if (div_rsp.done)
                begin
                    zw_next    = div_rsp.quotient[63:22] != '0;
                    y_next     = prod[38:16];
                    state_next = tps_pkg::ST_EXP_W;
                end
            end
            tps_pkg::ST_EXP_W:
            begin
                pmem_we  = 1'b1;
                pmem_wd  = wval;
                sum_next = sum_reg + tps_pkg::SUM_W'(wval);
                if (i_reg + CW'(1) == n_reg)
                begin
                    i_next     = '0;
                    state_next = tps_pkg::ST_NORM_RD;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = tps_pkg::ST_EXP_RD;
                end
            end
            tps_pkg::ST_NORM_RD:
            begin
                state_next = tps_pkg::ST_NORM_DIV;
            end
            tps_pkg::ST_NORM_DIV:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = tps_pkg::DIV_W'({pmem_rd, 24'b0});
                div_req.divisor  = tps_pkg::DIV_W'(sum_reg);
                state_next       = tps_pkg::ST_NORM_WAIT;
            end
            tps_pkg::ST_NORM_WAIT:
            begin
                if (div_rsp.done)
                begin
                    pmem_we = 1'b1;
                    pmem_wd = tps_pkg::W_W'(div_rsp.quotient[tps_pkg::P_W-1:0]);
                    if (i_reg + CW'(1) == n_reg)
                    begin
                        i_next     = '0;
                        k_next     = '0;
                        cum_next   = '0;
                        first_next = 1'b1;
                        have_next  = 1'b0;
                        state_next = tps_pkg::ST_SEL_SCAN;
                    end
                    else
                    begin
                        i_next     = i_reg + CW'(1);
                        state_next = tps_pkg::ST_NORM_RD;
                    end
                end
            end
            tps_pkg::ST_SEL_SCAN:
            begin
                // keep the largest entry that ranks after the last pick
                if (rdv_reg && elig && (!have_reg || (pcur > pbest_reg)))
                begin
                    pbest_next = pcur;
                    ibest_next = rdidx_reg;
                    have_next  = 1'b1;
                end
                if (i_reg != n_reg)
                begin
                    rdv_next   = 1'b1;
                    rdidx_next = i_reg[IW-1:0];
                    i_next     = i_reg + CW'(1);
                end
                else
                begin
                    state_next = tps_pkg::ST_SEL_COMMIT;
                end
            end
            tps_pkg::ST_SEL_COMMIT:
            begin
                omem_we    = 1'b1;
                cum_add    = cum_reg + tps_pkg::CUM_W'(pbest_reg);
                cum_next   = cum_add;
                k_next     = k_reg + CW'(1);
                plast_next = pbest_reg;
                ilast_next = ibest_reg;
                first_next = 1'b0;
                have_next  = 1'b0;
                i_next     = '0;
                if ((cum_add >= thr) || (k_reg + CW'(1) == n_reg))
                begin
                    m_next     = k_reg + CW'(1);
                    ns_next    = cum_add;
                    state_next = tps_pkg::ST_SAMP_RNG;
                end
                else
                begin
                    state_next = tps_pkg::ST_SEL_SCAN;
                end
            end
            tps_pkg::ST_SAMP_RNG:
            begin
                if (warm_reg == '0)
                begin
                    rng_next   = tps_pkg::xs_round(rng_reg);
                    state_next = tps_pkg::ST_SAMP_MUL;
                end
            end
            tps_pkg::ST_SAMP_MUL:
            begin
                target_next = rng_reg[63:40] * ns_reg;
                i_next      = '0;
                cum_next    = '0;
                state_next  = tps_pkg::ST_SAMP_RD;
            end
            tps_pkg::ST_SAMP_RD:
            begin
                state_next = tps_pkg::ST_SAMP_CHK;
            end
            tps_pkg::ST_SAMP_CHK:
            begin
                cum_add  = cum_reg + tps_pkg::CUM_W'(omem_rd.p);
                cum_next = cum_add;
                if ((target_reg < {cum_add, 24'b0}) || (i_reg + CW'(1) == m_reg))
                begin
                    res_next   = omem_rd.idx;
                    state_next = tps_pkg::ST_EMIT;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = tps_pkg::ST_SAMP_RD;
                end
            end
            tps_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || tokens.ready)
                begin
                    out_valid_next = 1'b1;
                    token_next     = tps_pkg::TOKEN_W'(res_reg);
                    state_next     = tps_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = tps_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tps_pkg::ST_LOAD;
            out_valid_reg <= 1'b0;
            temp_reg      <= tps_pkg::TEMP_RESET;
            topp_reg      <= tps_pkg::TOPP_ONE;
            rng_reg       <= tps_pkg::RNG_RESET;
            warm_reg      <= '0;
            rdv_reg       <= 1'b0;
            have_reg      <= 1'b0;
            first_reg     <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            temp_reg      <= temp_next;
            topp_reg      <= topp_next;
            rng_reg       <= rng_next;
            warm_reg      <= warm_next;
            rdv_reg       <= rdv_next;
            have_reg      <= have_next;
            first_reg     <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        mx_reg     <= mx_next;
        amax_reg   <= amax_next;
        i_reg      <= i_next;
        sum_reg    <= sum_next;
        y_reg      <= y_next;
        zw_reg     <= zw_next;
        plast_reg  <= plast_next;
        ilast_reg  <= ilast_next;
        pbest_reg  <= pbest_next;
        ibest_reg  <= ibest_next;
        rdidx_reg  <= rdidx_next;
        k_reg      <= k_next;
        cum_reg    <= cum_next;
        ns_reg     <= ns_next;
        m_reg      <= m_next;
        target_reg <= target_next;
        res_reg    <= res_next;
        token_reg  <= token_next;
    end

    `TPS_NEVER(a_div_unexpected, div_rsp.done && !(state_reg == tps_pkg::ST_EXP_WAIT || state_reg == tps_pkg::ST_NORM_WAIT))
    `TPS_NEVER(a_pick_missing, state_reg == tps_pkg::ST_SEL_COMMIT && !have_reg)

endmodule

// ===== design/top_p_token_sampler.sv =====
// ----------------------------------------------------------------------------
// Nucleus (top-p) token sampler
// Streams a logit vector in and returns one sampled token index.
// ----------------------------------------------------------------------------
// Usage:
//   logits : one signed Q16.16 logit per transaction; last_logit ends the
//            vector. Up to 65536 logits are kept, further ones are dropped.
//   tokens : one token index per vector, after its last logit.
//   cfg    : register writes (0 temperature, 1 top_p, 2 rng_seed), always
//            ready; write only while the block is idle.
// Throughput: logits load at one per cycle into the logit memory while the
// back end is loading; the queue fills and stalls them while it is busy.
// After the last logit: with temperature zero, the argmax tracked during
// loading is emitted directly; otherwise the time is set by two passes of
// the shared divider per logit and one full probability memory scan per
// nucleus position during the ordered selection.
// A finished result waits in an output register while the next vector
// loads; a stalled receiver only holds back the following result.
// Reset: registers return to temperature 1.0, top_p 1.0 and the default
// generator state; the memories are not cleared.
// ----------------------------------------------------------------------------
module top_p_token_sampler (
    input  logic       clk,
    input  logic       rst_n,
    tps_logit_if.sink  logits,
    tps_token_if.source tokens,
    tps_cfg_if.sink    cfg
);

    logic              push;
    logic              full;
    logic              pop;
    logic              empty;
    tps_pkg::q_entry_t wr_entry;
    tps_pkg::q_entry_t rd_entry;
    tps_pkg::div_req_t div_req;
    tps_pkg::div_rsp_t div_rsp;

    // front end: number logits and track the maximum
    tps_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .logits (logits),
        .push   (push),
        .entry  (wr_entry),
        .full   (full)
    );

    // queue: let loading run while the back end finishes a step
    tps_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (wr_entry),
        .full    (full),
        .pop     (pop),
        .rd_data (rd_entry),
        .empty   (empty)
    );

    // shared divider for the temperature scale and the normalisation
    tps_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // back end: softmax, ordered nucleus and sampling, or the greedy argmax
    tps_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (!empty),
        .q_data  (rd_entry),
        .q_pop   (pop),
        .tokens  (tokens),
        .cfg     (cfg),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// Nucleus token sampler testbench
// Streams logit vectors through the sampler under several register settings.
// A behavioural predictor works out the token of each vector, and the token
// stream is checked against it. Sender and receiver idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    import tps_pkg::*;

    localparam int unsigned STORE_DEPTH  = 65536;
    localparam logic [1:0]  CFG_NO_REG   = 2'd3;   // index with no register
    localparam logic [63:0] SEED_XOR     = 64'hdeadbeefcafe1234;
    localparam logic [63:0] RNG_START    = 64'h853c49e6748fea9b;
    localparam logic [63:0] LN2_RECIP    = 64'd94548;
    localparam logic [63:0] HALF_STEP    = 64'd4283353946;
    localparam int          REPORT_LIMIT = 10;

    typedef struct {
        logic signed [31:0] logit;
        logic               last;
        logic               drain;   // hold this transaction until all tokens are back
    } logit_item_t;

    logic clk;
    logic rst_n;

    tps_logit_if lg ();
    tps_token_if tk ();
    tps_cfg_if   cf ();

    top_p_token_sampler dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .logits (lg),
        .tokens (tk),
        .cfg    (cf)
    );

    // Predictor state: registers, stores and generator
    logic [15:0]        temp_q88;
    logic [16:0]        mass_q16;
    logic [63:0]        gen_state;
    logic signed [31:0] logit_mem [STORE_DEPTH];
    logic [63:0]        prob_mem  [STORE_DEPTH];
    int unsigned        rank_mem  [STORE_DEPTH];
    logic [63:0]        exp2_frac [256];
    int unsigned        fill_count;

    logit_item_t  pending_logits  [$];
    logic [15:0]  expected_tokens [$];
    int           mismatches;
    int           failures;
    logic         long_hold;
    event         hold_go;

    always #1 clk = ~clk;

    function automatic logic [63:0] xorshift_step(input logic [63:0] s);
        logic [63:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 7);
        t = t ^ (t << 17);
        return t;
    endfunction

    // Sampled (or greedy) token for the first n stored logits; advances the
    // generator on sampled vectors only.
    function automatic logic [15:0] sample_token(input int unsigned n);
        int unsigned        i, j, m, best, key;
        logic signed [31:0] mx;
        logic [63:0]        d, z, y, k, wv, total, thr, cum, nsum, r, target;
        best = 0;
        mx   = logit_mem[0];
        for (i = 1; i < n; i++)
        begin
            if (logit_mem[i] > mx)
            begin
                mx   = logit_mem[i];
                best = i;
            end
        end
        if (temp_q88 == 0)
            return best[15:0];

        total = 0;
        for (i = 0; i < n; i++)
        begin
            d  = longint'(mx) - longint'(logit_mem[i]);
            z  = (d << 8) / {48'd0, temp_q88};
            y  = (z * LN2_RECIP) >> 16;
            k  = y >> 16;
            wv = (k >= 64) ? 64'd0 : (exp2_frac[(y >> 8) & 64'd255] >> k);
            prob_mem[i] = wv;
            total += wv;
        end
        for (i = 0; i < n; i++)
            prob_mem[i] = (prob_mem[i] << 24) / total;

        // stable descending order, ties to the lower index
        for (i = 0; i < n; i++)
            rank_mem[i] = i;
        for (i = 1; i < n; i++)
        begin
            key = rank_mem[i];
            j   = i;
            while (j > 0 && prob_mem[rank_mem[j - 1]] < prob_mem[key])
            begin
                rank_mem[j] = rank_mem[j - 1];
                j--;
            end
            rank_mem[j] = key;
        end

        thr = (mass_q16 > 17'd65536) ? 64'd65536 << 8 : {47'd0, mass_q16} << 8;
        cum = 0;
        m   = n;
        for (i = 0; i < n; i++)
        begin
            cum += prob_mem[rank_mem[i]];
            if (cum >= thr)
            begin
                m = i + 1;
                break;
            end
        end
        nsum = 0;
        for (i = 0; i < m; i++)
            nsum += prob_mem[rank_mem[i]];

        gen_state = xorshift_step(gen_state);
        r         = gen_state >> 40;
        target    = r * nsum;
        cum       = 0;
        for (i = 0; i < m; i++)
        begin
            cum += prob_mem[rank_mem[i]];
            if (target < (cum << 24))
                return rank_mem[i][15:0];
        end
        return rank_mem[m - 1][15:0];
    endfunction

    // ------------------------------------------------------------------------
    // Logit driver: bursts of random length separated by random gaps. Record
    // each accepted transaction in the predictor, which queues the expected
    // token when the vector closes.
    // ------------------------------------------------------------------------
    int unsigned burst_left;
    int unsigned gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lg.valid      <= 1'b0;
            lg.logit      <= '0;
            lg.last_logit <= 1'b0;
            burst_left    = 1;
            gap_left      = 0;
        end
        else
        begin
            if (lg.valid && lg.ready)
            begin
                // drop logits past the store depth, as the block does
                if (fill_count < STORE_DEPTH)
                begin
                    logit_mem[fill_count] = lg.logit;
                    fill_count++;
                end
                if (lg.last_logit)
                begin
                    expected_tokens.push_back(sample_token(fill_count));
                    fill_count = 0;
                end
            end
            // only move on once the current transaction has gone
            if (!lg.valid || lg.ready)
            begin
                if (gap_left > 0)
                begin
                    lg.valid <= 1'b0;
                    gap_left--;
                end
                else if (pending_logits.size() > 0 &&
                         !(pending_logits[0].drain && expected_tokens.size() > 0))
                begin
                    logit_item_t it;
                    it = pending_logits.pop_front();
                    lg.valid      <= 1'b1;
                    lg.logit      <= it.logit;
                    lg.last_logit <= it.last;
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        // roughly a third of bursts run straight on
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    lg.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Token receiver: its own stall pattern, chosen at random from four modes, and
    // overridden by the long hold-off.
    // ------------------------------------------------------------------------
    int unsigned stall_mode;
    int unsigned stall_tick;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tk.ready   <= 1'b0;
            stall_mode = 0;
            stall_tick = 0;
        end
        else
        begin
            if (tk.valid && tk.ready)
            begin
                if (expected_tokens.size() == 0)
                begin
                    failures++;
                    if (mismatches++ < REPORT_LIMIT)
                        $display("unexpected token %0d with nothing pending", tk.token_index);
                end
                else
                begin
                    logic [15:0] want;
                    want = expected_tokens.pop_front();
                    if (tk.token_index !== want)
                    begin
                        failures++;
                        if (mismatches++ < REPORT_LIMIT)
                            $display("token_index mismatch: expected %0d, got %0d",
                                     want, tk.token_index);
                    end
                end
            end
            stall_tick++;
            if (stall_tick % 64 == 0)
                stall_mode = $urandom_range(0, 3);
            if (long_hold)
                tk.ready <= 1'b0;
            else
                case (stall_mode)
                    0: tk.ready <= 1'b1;
                    1: tk.ready <= $urandom_range(0, 1);
                    2: tk.ready <= ($urandom_range(0, 3) == 0);
                    default: tk.ready <= stall_tick[0];
                endcase
        end
    end

    // Long receiver hold-off, counted here so that the sender keeps offering
    initial
    begin
        long_hold = 1'b0;
        forever
        begin
            @(hold_go);
            @(posedge clk);
            long_hold <= 1'b1;
            repeat (800) @(posedge clk);
            long_hold <= 1'b0;
        end
    end

    // Abandon a hung run
    initial
    begin
        #20_000_000;
        $display("[top_p_token_sampler] ERROR");
        $finish;
    end

    // Write one register; mirror it in the predictor once the block takes it
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        @(posedge clk);
        cf.valid <= 1'b1;
        cf.index <= idx;
        cf.data  <= value;
        do
            @(posedge clk);
        while (!cf.ready);
        cf.valid <= 1'b0;
        case (idx)
            CFG_TEMPERATURE: temp_q88 = value[15:0];
            CFG_TOP_P:       mass_q16 = value[16:0];
            CFG_RNG_SEED:
            begin
                gen_state = value ^ SEED_XOR;
                if (gen_state == 0)
                    gen_state = 64'd1;
                repeat (8) gen_state = xorshift_step(gen_state);
            end
            default: ;
        endcase
    endtask

    // Wait for the stimulus to drain and every token to return, then let the
    // block finish any trailing work.
    task automatic settle();
        while (pending_logits.size() > 0 || lg.valid || expected_tokens.size() > 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic push_logit(input logic signed [31:0] v, input logic last,
                              input logic drain = 1'b0);
        logit_item_t it;
        it.logit = v;
        it.last  = last;
        it.drain = drain;
        pending_logits.push_back(it);
    endtask

    // Queue one vector of n logits in one of several value styles
    task automatic push_vector(input int unsigned n, input logic drain);
        int unsigned        style;
        logic signed [31:0] base, v;
        style = $urandom_range(0, 3);
        base  = $signed($urandom) >>> 2;
        for (int unsigned i = 0; i < n; i++)
        begin
            case (style)
                0: v = $urandom;                                    // whole range
                1: v = base + $signed($urandom_range(0, 8 << 16));  // spread of a few units
                2: v = $signed($urandom_range(0, 2) << 16);         // heavy ties
                default: v = base + $signed($urandom_range(0, 255));
            endcase
            push_logit(v, i == n - 1, drain && i == 0);
        end
    endtask

    function automatic int unsigned pick_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return $urandom_range(1, 10);
        else if (roll < 97)
            return $urandom_range(11, 24);
        return $urandom_range(40, 64);
    endfunction

    initial
    begin
        logic [15:0] temps [8] = '{16'd16, 16'd0, 16'd65535, 16'd512,
                                   16'd1, 16'd256, 16'd3000, 16'd0};
        logic [16:0] masses [8] = '{17'd32768, 17'd65536, 17'd0, 17'd131071,
                                    17'd60000, 17'd1, 17'd65535, 17'd20000};
        logic [63:0] seed;
        int unsigned added, len;

        clk        = 1'b0;
        rst_n      = 1'b0;
        lg.valid   = 1'b0;
        lg.logit   = '0;
        lg.last_logit = 1'b0;
        tk.ready   = 1'b0;
        cf.valid   = 1'b0;
        cf.index   = '0;
        cf.data    = '0;
        mismatches = 0;
        failures   = 0;
        fill_count = 0;
        temp_q88   = 16'd256;
        mass_q16   = 17'd65536;
        gen_state  = RNG_START;
        exp2_frac[0] = 64'd1 << 32;
        for (int j = 0; j < 255; j++)
            exp2_frac[j + 1] = (exp2_frac[j] * HALF_STEP + (64'd1 << 31)) >> 32;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: reset settings, extreme logits, one-logit vector, ties
        push_logit(32'sh7FFFFFFF, 1'b0);
        push_logit(32'sh80000000, 1'b0);
        push_logit(32'sh00000000, 1'b0);
        push_logit(32'sh00010000, 1'b1);
        push_logit($urandom, 1'b1);
        repeat (3) push_logit(32'sh00050000, 1'b0);
        push_logit(32'sh00050000, 1'b1);
        settle();

        // Greedy: tie between the maxima goes to the lower index
        write_reg(CFG_TEMPERATURE, 64'd0);
        push_logit(32'sd3, 1'b0);
        push_logit(32'sd9, 1'b0);
        push_logit(32'sd9, 1'b0);
        push_logit(-32'sd1, 1'b1);
        push_logit(32'sh80000000, 1'b0);
        push_logit(32'sh80000000, 1'b1);
        settle();

        // Coldest temperature with a zero mass threshold
        write_reg(CFG_TEMPERATURE, 64'd1);
        write_reg(CFG_TOP_P, 64'd0);
        for (int i = 0; i < 4; i++)
            push_logit(32'sd100 + i, i == 3);
        settle();

        // Hottest temperature, oversized threshold, seed that cancels the mask
        write_reg(CFG_TEMPERATURE, 64'd65535);
        write_reg(CFG_TOP_P, 64'd131071);
        write_reg(CFG_RNG_SEED, SEED_XOR);
        write_reg(CFG_NO_REG, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int i = 0; i < 6; i++)
            push_logit($signed(i << 14), i == 5);
        settle();

        // Random phases, each under its own settings
        for (int ph = 0; ph < 8; ph++)
        begin
            seed = {$urandom, $urandom};
            if (ph == 1)
                seed = '1;
            else if (ph == 5)
                seed = '0;
            write_reg(CFG_TEMPERATURE, {48'd0, temps[ph]});
            write_reg(CFG_TOP_P, {47'd0, masses[ph]});
            write_reg(CFG_RNG_SEED, seed);
            if (ph == 3)
            begin
                // fill the block while the receiver holds off
                -> hold_go;
                for (int v = 0; v < 12; v++)
                    push_vector($urandom_range(1, 3), 1'b0);
            end
            added = 0;
            while (added < 200)
            begin
                len = pick_length();
                push_vector(len, $urandom_range(0, 19) == 0);
                added += len;
            end
            // a lone one-logit vector with the largest logit
            if (ph == 6)
                push_logit(32'sh7FFFFFFF, 1'b1);
            settle();
        end

        // Overflow: logits beyond the store depth are dropped, greedy only
        write_reg(CFG_TEMPERATURE, 64'd0);
        for (int unsigned i = 0; i < STORE_DEPTH + 4; i++)
        begin
            if (i >= STORE_DEPTH)
                push_logit(32'sh7FFFFFFF, i == STORE_DEPTH + 3);
            else if (i == 40000 || i == 50000)
                push_logit(32'sd5000, 1'b0);
            else
                push_logit($signed($urandom_range(0, 999)), 1'b0);
        end
        settle();
        repeat (50) @(posedge clk);

        if (failures == 0 && expected_tokens.size() == 0)
            $display("[top_p_token_sampler] OK");
        else
            $display("[top_p_token_sampler] ERROR");
        $finish;
    end

endmodule
